// ----- design/lhm_pkg.sv -----
// Shared types and constants for the latency histogram monitor.
package lhm_pkg;

  // Field widths
  localparam int LAT_W   = 32;
  localparam int WIDTH_W = 16;
  localparam int KIND_W  = 2;
  localparam int RIDX_W  = 6;
  localparam int OIDX_W  = 6;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 32;

  // Defaults
  localparam int                 DEF_NUM_BINS      = 64;
  localparam logic [WIDTH_W-1:0] DEF_BUCKET_WIDTH  = 16'd10;
  localparam logic [CFG_W-1:0]   DEF_OVERFLOW_EDGE = 32'd640;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BUCKET_WIDTH  = 1'b0;
  localparam logic CFG_OVERFLOW_EDGE = 1'b1;

  typedef enum logic [3:0] {
    S_INIT_SWEEP,
    S_IDLE,
    S_CLR_SWEEP,
    S_DIV,
    S_BIN,
    S_READ,
    S_UPD_SAMPLE,
    S_UPD_READ,
    S_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept_sample;
    logic accept_read;
    logic div_step;
    logic bin_load;
    logic mem_read;
    logic update_sample;
    logic update_read;
    logic sweep_start;
    logic sweep_step;
    logic clear_reply;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic sweep_last;
  } dp_status_t;

endpackage

// ----- design/lhm_ctrl.sv -----
// Sequencer for the latency histogram monitor.
module lhm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lhm_pkg::KIND_W-1:0]  kind,
  input  lhm_pkg::dp_status_t         stat,
  output lhm_pkg::ctrl_cmd_t          cmd,
  output logic                        busy,
  output logic                        done
);
  import lhm_pkg::*;

  ctrl_state_t state, state_next;
  logic        kind_is_sample;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_SAMPLE: begin
              cmd.accept_sample = 1'b1;
              state_next        = S_DIV;
            end
            KIND_CLEAR: begin
              cmd.sweep_start = 1'b1;
              state_next      = S_CLR_SWEEP;
            end
            default: begin
              // read, and the unused code handled as a read
              cmd.accept_read = 1'b1;
              state_next      = S_READ;
            end
          endcase
        end
      end
      S_CLR_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.clear_reply = 1'b1;
          state_next      = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_BIN;
      end
      S_BIN: begin
        cmd.bin_load = 1'b1;
        state_next   = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = (kind_is_sample) ? S_UPD_SAMPLE : S_UPD_READ;
      end
      S_UPD_SAMPLE: begin
        cmd.update_sample = 1'b1;
        state_next        = S_EMIT;
      end
      S_UPD_READ: begin
        cmd.update_read = 1'b1;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Remember whether the request in flight is a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_is_sample <= 1'b0;
    end else if (cmd.accept_sample) begin
      kind_is_sample <= 1'b1;
    end else if (cmd.accept_read) begin
      kind_is_sample <= 1'b0;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_EMIT);

endmodule

// ----- design/lhm_dpath.sv -----
// Datapath: bin counter memory, serial divider, edge multiplier, result registers.
module lhm_dpath #(
  parameter int NUM_BINS = lhm_pkg::DEF_NUM_BINS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lhm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [lhm_pkg::LAT_W-1:0]    latency,
  input  logic [lhm_pkg::RIDX_W-1:0]   bucket_index,
  input  lhm_pkg::ctrl_cmd_t           cmd,
  output lhm_pkg::dp_status_t          stat,
  output logic [lhm_pkg::OIDX_W-1:0]   bin_index,
  output logic [lhm_pkg::CNT_W-1:0]    bin_count,
  output logic [lhm_pkg::CFG_W-1:0]    bin_edge,
  output logic [lhm_pkg::LAT_W-1:0]    max_seen,
  output logic [lhm_pkg::CNT_W-1:0]    sample_count,
  output logic                         is_last_bin
);
  import lhm_pkg::*;

  localparam int BW    = $clog2(NUM_BINS);
  localparam int DCW   = $clog2(LAT_W);
  localparam logic [BW-1:0]    LAST_IDX  = BW'(NUM_BINS - 1);
  localparam logic [LAT_W-1:0] LAST_WIDE = LAT_W'(NUM_BINS - 1);
  localparam logic [DCW-1:0]   DIV_LAST  = DCW'(LAT_W - 1);

  // Configuration registers
  logic [WIDTH_W-1:0] bucket_width;
  logic [CFG_W-1:0]   overflow_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width  <= DEF_BUCKET_WIDTH;
      overflow_edge <= DEF_OVERFLOW_EDGE;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUCKET_WIDTH) begin
        bucket_width <= cfg_data[WIDTH_W-1:0];
      end else begin
        overflow_edge <= cfg_data;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; a zero width gives all ones
  logic [LAT_W-1:0]   lat;
  logic [LAT_W-1:0]   quo;
  logic [WIDTH_W-1:0] rem;
  logic [DCW-1:0]     div_cnt;
  logic [WIDTH_W:0]   rem_sh;
  logic               q_bit;

  assign rem_sh = {rem, quo[LAT_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, bucket_width});

  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      lat     <= latency;
      quo     <= latency;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= {quo[LAT_W-2:0], q_bit};
      rem     <= q_bit ? WIDTH_W'(rem_sh - {1'b0, bucket_width}) : rem_sh[WIDTH_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign stat.div_last = (div_cnt == DIV_LAST);

  // Bin index: saturated quotient or saturated read index
  logic [BW-1:0] idx;
  always_ff @(posedge clk) begin
    if (cmd.bin_load) begin
      idx <= (quo > LAST_WIDE) ? LAST_IDX : quo[BW-1:0];
    end else if (cmd.accept_read) begin
      idx <= (LAT_W'(bucket_index) > LAST_WIDE) ? LAST_IDX : BW'(bucket_index);
    end
  end

  // Upper edge of the selected bin
  logic [BW+WIDTH_W:0] edge_prod;
  logic [CFG_W-1:0]    edge_val;
  assign edge_prod = ({1'b0, idx} + (BW+1)'(1)) * bucket_width;

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      edge_val <= (idx == LAST_IDX) ? overflow_edge : CFG_W'(edge_prod);
    end
  end

  // Clearing sweep counter
  logic [BW-1:0] sweep_cnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  assign stat.sweep_last = (sweep_cnt == LAST_IDX);

  // Bin counter memory, one write and one registered read port
  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = rd_data + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[sweep_cnt] <= '0;
    end else if (cmd.update_sample) begin
      mem[idx] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_data <= mem[idx];
    end
  end

  // Running maximum and sample total
  logic [LAT_W-1:0] max_latency;
  logic [CNT_W-1:0] total_samples;
  logic [LAT_W-1:0] max_new;
  logic [CNT_W-1:0] total_new;

  assign max_new   = (lat > max_latency) ? lat : max_latency;
  assign total_new = total_samples + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      max_latency   <= '0;
      total_samples <= '0;
    end else if (cmd.update_sample) begin
      max_latency   <= max_new;
      total_samples <= total_new;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.clear_reply) begin
      bin_index    <= '0;
      bin_count    <= '0;
      bin_edge     <= '0;
      max_seen     <= '0;
      sample_count <= '0;
      is_last_bin  <= 1'b0;
    end else if (cmd.update_sample) begin
      bin_index    <= OIDX_W'(idx);
      bin_count    <= cnt_inc;
      bin_edge     <= edge_val;
      max_seen     <= max_new;
      sample_count <= total_new;
      is_last_bin  <= (idx == LAST_IDX);
    end else if (cmd.update_read) begin
      bin_index    <= OIDX_W'(idx);
      bin_count    <= rd_data;
      bin_edge     <= edge_val;
      max_seen     <= max_latency;
      sample_count <= total_samples;
      is_last_bin  <= (idx == LAST_IDX);
    end
  end

endmodule

// ----- design/latency_histogram_monitor_core.sv -----
// Latency histogram monitor: per-bin counters with an overflow bin, max and total.
// Sample request: the 32-step serial divider (latency / bucket_width) runs after acceptance,
//   then the bin counter is read and updated; a new request is taken only after done.
// Read request: the selected counter is read. Clear request: zeroes all bins, max and total.
// Reset (sync, active high): a clearing pass zeroes the bin memory,
//   busy stays high meanwhile. Results are strobed by done for one cycle; no stall.
module latency_histogram_monitor_core #(
  parameter int NUM_BINS = lhm_pkg::DEF_NUM_BINS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lhm_pkg::KIND_W-1:0]   kind,
  input  logic [lhm_pkg::LAT_W-1:0]    latency,
  input  logic [lhm_pkg::RIDX_W-1:0]   bucket_index,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lhm_pkg::CFG_W-1:0]    cfg_data,
  output logic                         done,
  output logic [lhm_pkg::OIDX_W-1:0]   bin_index,
  output logic [lhm_pkg::CNT_W-1:0]    bin_count,
  output logic [lhm_pkg::CFG_W-1:0]    bin_edge,
  output logic [lhm_pkg::LAT_W-1:0]    max_seen,
  output logic [lhm_pkg::CNT_W-1:0]    sample_count,
  output logic                         is_last_bin
);
  import lhm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  lhm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lhm_dpath #(
    .NUM_BINS (NUM_BINS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .latency      (latency),
    .bucket_index (bucket_index),
    .cmd          (cmd),
    .stat         (stat),
    .bin_index    (bin_index),
    .bin_count    (bin_count),
    .bin_edge     (bin_edge),
    .max_seen     (max_seen),
    .sample_count (sample_count),
    .is_last_bin  (is_last_bin)
  );

endmodule
